// ----- sv/ola_pkg.sv -----
// Package for the ordered list engine: sizes, request and status codes, beat structs.
`default_nettype none

package ola_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 6;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_END   = 3'd1;
    localparam logic [2:0] REQ_INS_POS   = 3'd2;
    localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [2:0] REQ_DEL_END   = 3'd4;
    localparam logic [2:0] REQ_DEL_POS   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]              req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } ola_req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] removed_value;
        logic [LEN_W-1:0]        list_length;
    } ola_rsp_t;

    // broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] at;
    } ola_shift_t;

endpackage

`default_nettype wire

// ----- sv/ola_cell.sv -----
// One list cell: holds one element and shifts toward its neighbors on insert or delete.
`default_nettype none

module ola_cell
    import ola_pkg::*;
(
    input  wire logic                    clk,
    input  wire ola_shift_t              ctrl,
    input  wire logic [IDX_W-1:0]        idx,
    input  wire logic signed [VAL_W-1:0] new_value,
    input  wire logic signed [VAL_W-1:0] prev_data,
    input  wire logic signed [VAL_W-1:0] next_data,
    output logic signed [VAL_W-1:0]      data,
    output logic signed [VAL_W-1:0]      hit_data
);

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (idx > ctrl.at)
            begin
                data_next = prev_data;
            end
            else if (idx == ctrl.at)
            begin
                data_next = new_value;
            end
        end
        else if (ctrl.del)
        begin
            if (idx >= ctrl.at)
            begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (ctrl.del && idx == ctrl.at) ? data_reg : '0;

endmodule

`default_nettype wire

// ----- sv/ordered_list_insert_delete.sv -----
// Top level of the ordered list engine: request decode, cell chain, length and result registers.
// One request per clock: a request taken with start shows its result with done on the
// next cycle, and busy never rises. Every element sits in its own cell of a shifting
// chain, so an insert or delete at any position shifts all cells at once. done is high for exactly
// one cycle per result, rsp keeps it until the next request, and the receiver cannot hold it off.
`default_nettype none

module ordered_list_insert_delete
    import ola_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire ola_req_t req,
    output logic          done,
    output ola_rsp_t      rsp
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    ola_rsp_t         rsp_reg;
    ola_rsp_t         rsp_next;
    ola_shift_t       shift;
    logic             take;
    logic             full;
    logic             empty;
    logic             pos_ok;
    logic [1:0]       status;

    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic signed [VAL_W-1:0] cell_hit  [CAPACITY];
    logic signed [VAL_W-1:0] removed;

    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign full  = cnt_reg >= CNT_W'(CAPACITY);
    assign empty = cnt_reg == '0;
    assign pos_ok = CMP_W'(req.position) < CMP_W'(cnt_reg);

    always_comb
    begin
        status    = ST_OK;
        shift.ins = 1'b0;
        shift.del = 1'b0;
        shift.at  = '0;
        unique case (req.req_type)
            REQ_INS_FRONT:
            begin
                if (full) status = ST_FULL;
                else shift.ins = 1'b1;
            end
            REQ_INS_END:
            begin
                shift.at = IDX_W'(cnt_reg);
                if (full) status = ST_FULL;
                else shift.ins = 1'b1;
            end
            REQ_INS_POS:
            begin
                shift.at = IDX_W'(req.position);
                if (empty) status = ST_EMPTY;
                else if (!pos_ok) status = ST_RANGE;
                else if (full) status = ST_FULL;
                else shift.ins = 1'b1;
            end
            REQ_DEL_FRONT:
            begin
                if (empty) status = ST_EMPTY;
                else shift.del = 1'b1;
            end
            REQ_DEL_END:
            begin
                shift.at = IDX_W'(cnt_reg - CNT_W'(1));
                if (empty) status = ST_EMPTY;
                else shift.del = 1'b1;
            end
            REQ_DEL_POS:
            begin
                shift.at = IDX_W'(req.position);
                if (empty) status = ST_EMPTY;
                else if (!pos_ok) status = ST_RANGE;
                else shift.del = 1'b1;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        shift.ins = shift.ins && take;
        shift.del = shift.del && take;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] prev_d;
        logic signed [VAL_W-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = req.value;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_inner
            assign next_d = cell_data[i+1];
        end

        ola_cell u_cell (
            .clk       (clk),
            .ctrl      (shift),
            .idx       (IDX_W'(i)),
            .new_value (req.value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i]),
            .hit_data  (cell_hit[i])
        );
    end

    always_comb
    begin
        removed = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            removed = removed | cell_hit[i];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (shift.ins)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (shift.del)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        rsp_next.status        = status;
        rsp_next.removed_value = removed;
        rsp_next.list_length   = LEN_W'(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("result beat missing after request");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.removed_value == '0)
        else $error("failed request returned a value");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == ST_FULL |-> rsp.list_length == LEN_W'(CAPACITY))
        else $error("full status with list not full");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> $stable(cnt_reg))
        else $error("count changed without a request");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for ordered_list_insert_delete: directed and random requests checked against a list model.
`default_nettype none

module tb
    import ola_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int N_ITEMS    = 1150;
    localparam int IDLE_LIMIT = 1000;

    class list_scoreboard;
        logic signed [VAL_W-1:0] cells[$];
        ola_rsp_t                pending[$];
        int                      errors = 0;

        function int count();
            return cells.size();
        endfunction

        function void note_request(ola_req_t r);
            ola_rsp_t e;
            int       n;
            int       p;
            n = cells.size();
            p = int'(r.position);
            e.status        = ST_OK;
            e.removed_value = '0;
            case (r.req_type)
                REQ_INS_FRONT:
                    if (n >= CAPACITY) e.status = ST_FULL;
                    else cells.push_front(r.value);
                REQ_INS_END:
                    if (n >= CAPACITY) e.status = ST_FULL;
                    else cells.push_back(r.value);
                REQ_INS_POS:
                    if (n == 0) e.status = ST_EMPTY;
                    else if (p >= n) e.status = ST_RANGE;
                    else if (n >= CAPACITY) e.status = ST_FULL;
                    else cells.insert(p, r.value);
                REQ_DEL_FRONT:
                    if (n == 0) e.status = ST_EMPTY;
                    else e.removed_value = cells.pop_front();
                REQ_DEL_END:
                    if (n == 0) e.status = ST_EMPTY;
                    else e.removed_value = cells.pop_back();
                REQ_DEL_POS:
                    if (n == 0) e.status = ST_EMPTY;
                    else if (p >= n) e.status = ST_RANGE;
                    else
                    begin
                        e.removed_value = cells[p];
                        cells.delete(p);
                    end
                default: ;
            endcase
            e.list_length = LEN_W'(cells.size());
            pending.push_back(e);
        endfunction

        function void check_result(ola_rsp_t got);
            ola_rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: status %0d removed %0d length %0d",
                       got.status, got.removed_value, got.list_length);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, got.status);
                errors++;
            end
            if (got.removed_value !== e.removed_value)
            begin
                $error("removed_value: expected %0d, got %0d", e.removed_value,
                       got.removed_value);
                errors++;
            end
            if (got.list_length !== e.list_length)
            begin
                $error("list_length: expected %0d, got %0d", e.list_length, got.list_length);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ola_req_t req;
    logic     done;
    ola_rsp_t rsp;

    list_scoreboard sb = new;
    int             idle_cycles = 0;

    ordered_list_insert_delete i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // accept, check and watchdog, all on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy) sb.note_request(req);
            if (done) sb.check_result(rsp);
            if ((start && !busy) || done) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic ola_req_t make_req(logic [2:0] t, int p, logic [VAL_W-1:0] v);
        ola_req_t r;
        r.req_type = t;
        r.position = POS_W'(p);
        r.value    = v;
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // mode: 0 grow, 1 shrink, 2 balanced, 3 noise
    function automatic ola_req_t pick_req(int mode);
        int       n;
        int       r;
        int       p;
        logic [2:0] t;
        n = sb.count();
        r = $urandom_range(0, 99);
        if (r < 2) t = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        else
        begin
            case (mode)
                0: t = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, 2))
                                                    : 3'($urandom_range(3, 5));
                1: t = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(3, 5))
                                                    : 3'($urandom_range(0, 2));
                default: t = 3'($urandom_range(0, 5));
            endcase
        end
        if (n > 0 && $urandom_range(0, 99) < ((mode == 3) ? 40 : 88))
            p = $urandom_range(0, n - 1);
        else
            p = $urandom_range(0, 31);
        return make_req(t, p, pick_value());
    endfunction

    task automatic idle_gap(int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_req(ola_req_t r);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    initial
    begin
        ola_req_t directed[$];
        int       sent;
        int       mode;
        int       span;
        bit       quiet;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed = '{
            make_req(REQ_DEL_FRONT, 0, 32'h1234_5678),
            make_req(REQ_DEL_END, 0, 32'h0),
            make_req(REQ_DEL_POS, 0, 32'h0),
            make_req(REQ_INS_POS, 0, 32'h5555_AAAA),
            make_req(REQ_SPARE_A, 31, 32'hFFFF_FFFF),
            make_req(REQ_SPARE_B, 0, 32'h0F0F_0F0F),
            make_req(REQ_INS_FRONT, 0, 32'h7FFF_FFFF),
            make_req(REQ_INS_END, 31, 32'h8000_0000),
            make_req(REQ_INS_POS, 0, 32'hFFFF_FFFF),
            make_req(REQ_INS_POS, 31, 32'h1),
            make_req(REQ_INS_POS, 3, 32'h2),
            make_req(REQ_INS_POS, 1, 32'h0),
            make_req(REQ_SPARE_B, 1, 32'h3),
            make_req(REQ_DEL_POS, 31, 32'h0),
            make_req(REQ_DEL_POS, 4, 32'h0),
            make_req(REQ_DEL_POS, 1, 32'hFFFF_FFFF),
            make_req(REQ_DEL_END, 0, 32'h0),
            make_req(REQ_DEL_FRONT, 0, 32'h0),
            make_req(REQ_DEL_POS, 0, 32'h0),
            make_req(REQ_DEL_END, 0, 32'h0),
            make_req(REQ_INS_END, 0, 32'hDEAD_BEEF)
        };
        foreach (directed[k])
        begin
            idle_gap((k % 4 == 3) ? 1 : 0);
            send_req(directed[k]);
        end

        sent = 0;
        while (sent < N_ITEMS)
        begin
            mode  = $urandom_range(0, 3);
            span  = $urandom_range(20, 80);
            quiet = ($urandom_range(0, 3) == 0);
            repeat (span)
            begin
                idle_gap(pick_gap(quiet));
                send_req(pick_req(mode));
                sent++;
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- ordered_list_insert_delete.f -----
sv/ola_pkg.sv
sv/ola_cell.sv
sv/ordered_list_insert_delete.sv
verif/tb.sv
